@@ hdl/itr_pkg.sv @@
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, character codes and helpers for the integer-to-text block.
// ----------------------------------------------------------------------------
`default_nettype none

package itr_pkg;

   localparam int VALUE_FIELD_BITS = 32;
   localparam int RADIX_BITS       = 5;
   localparam int DIGIT_BITS       = 5;
   localparam int CHAR_BITS        = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET  = 5'd10;
   localparam logic [RADIX_BITS-1:0] BASE_MIN     = 5'd2;
   localparam logic [RADIX_BITS-1:0] BASE_DEC     = 5'd10;
   localparam logic [RADIX_BITS-1:0] BASE_OCT     = 5'd8;
   localparam logic [RADIX_BITS-1:0] BASE_HEX     = 5'd16;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_BITS-1:0] CHAR_X     = 8'h78;  // 'x'
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h41;  // 'A'
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 5'd10;

   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] value;
      logic                        is_signed;
      logic                        force_hex;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_DIG_WAIT,
      ST_DIG
   } itr_state_type;

   // digit value to ASCII, letters past nine in upper case
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ext;
      ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_A + ext - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DIGIT_TEN};
      end
   endfunction

endpackage

`default_nettype wire

@@ hdl/itr_divider.sv @@
// ----------------------------------------------------------------------------
// itr_divider
// Bit-serial restoring divider: one quotient bit per cycle by a 5-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_divider
   import itr_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [RADIX_BITS-1:0] divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [DIGIT_BITS-1:0]      remainder
);

   localparam int CW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DIGIT_BITS-1:0] r_ff, r_in;
   logic [RADIX_BITS-1:0] d_ff, d_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIGIT_BITS:0]   trial;
   logic [DIGIT_BITS:0]   diff;
   logic                  ge;

   assign trial = {r_ff, q_ff[VALUE_BITS-1]};
   assign ge    = trial >= {1'b0, d_ff};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], ge};
         r_in   = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(VALUE_BITS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

@@ hdl/itr_digit_stack.sv @@
// ----------------------------------------------------------------------------
// itr_digit_stack
// LIFO of digits: pushed least significant first, popped most significant
// first. Top entry read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_digit_stack
   import itr_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [DIGIT_BITS-1:0]        push_digit,
   input  wire logic                         pop,
   output logic [$clog2(DEPTH+1)-1:0]        count,
   output logic [DIGIT_BITS-1:0]             top_digit
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DIGIT_BITS-1:0] mem [DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      top_idx;
   logic [DIGIT_BITS-1:0] rd_ff;

   assign top_idx = count_ff - CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[count_ff[AW-1:0]] <= push_digit;
      end
      rd_ff <= mem[top_idx[AW-1:0]];
   end

   assign count     = count_ff;
   assign top_digit = rd_ff;

endmodule

`default_nettype wire

@@ hdl/integer_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts one integer item into a stream of ASCII character items.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one integer item (value, is_signed, force_hex), taken when
//            req_valid is high and req_stall is low. req_stall stays high
//            from the cycle after an accept until the last character has
//            been loaded into the output register.
//   rsp_*  : character items, most significant first; last marks the end.
//   csr_*  : radix register (reset 10); write only while the block is idle.
// Conversion:
//   Digits come from repeated division by the radix in a bit-serial divider,
//   least significant first, and are pushed onto a digit stack. The sign and
//   prefix characters are then emitted, and each digit passes through a wait
//   state (ST_DIG_WAIT) for the registered stack read before it is emitted.
// Reset clears the radix to 10, drops any item in flight and empties the
// output register. A stalled receiver holds the output register; character
// emission pauses on it and resumes once the character is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_text
   import itr_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [RADIX_BITS-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(VALUE_BITS+1);

   // configuration
   logic [RADIX_BITS-1:0] radix_ff;

   // per-item control
   itr_state_type         state_ff, state_in;
   logic [RADIX_BITS-1:0] base_ff, base_in;
   logic                  neg_ff, neg_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // datapath
   logic                  accept;
   logic                  out_free;
   logic [VALUE_BITS-1:0] v_in;
   logic [VALUE_BITS-1:0] mag_in;
   logic                  neg_req;
   logic [RADIX_BITS-1:0] base_req;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [RADIX_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quot;
   logic [DIGIT_BITS-1:0] div_rem;

   logic                  push;
   logic                  pop;
   logic [CNT_W-1:0]      dig_count;
   logic [DIGIT_BITS-1:0] top_digit;

   logic                  emit;
   rsp_type               emit_item;
   logic                  has_prefix;
   logic                  quot_zero;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // field is 32 bits; the integer itself is VALUE_BITS wide
   assign v_in = VALUE_BITS'(req_data.value);

   // force_hex wins over radix and sign; radix 0/1 fall back to decimal
   always_comb begin
      if (req_data.force_hex) begin
         base_req = BASE_HEX;
      end else if (radix_ff < BASE_MIN) begin
         base_req = BASE_DEC;
      end else begin
         base_req = radix_ff;
      end
   end

   assign neg_req = req_data.is_signed && !req_data.force_hex && v_in[VALUE_BITS-1];
   // most negative value negates to itself, which is the right magnitude
   assign mag_in  = neg_req ? (~v_in + VALUE_BITS'(1)) : v_in;

   assign has_prefix = (base_ff == BASE_OCT) || (base_ff == BASE_HEX);
   assign quot_zero  = (div_quot == '0);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done && quot_zero) begin
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (has_prefix) begin
                  state_in = ST_PFX0;
               end else begin
                  state_in = ST_DIG_WAIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = has_prefix ? ST_PFX0 : ST_DIG_WAIT;
            end
         end
         ST_PFX0: begin
            if (out_free) begin
               state_in = (base_ff == BASE_HEX) ? ST_PFXX : ST_DIG_WAIT;
            end
         end
         ST_PFXX: begin
            if (out_free) begin
               state_in = ST_DIG_WAIT;
            end
         end
         ST_DIG_WAIT: begin
            state_in = ST_DIG;
         end
         ST_DIG: begin
            if (out_free) begin
               state_in = (dig_count == CNT_W'(1)) ? ST_IDLE : ST_DIG_WAIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------ outputs
   always_comb begin
      req_stall              = 1'b1;
      div_start              = 1'b0;
      div_dividend           = div_quot;
      div_divisor            = base_ff;
      push                   = 1'b0;
      pop                    = 1'b0;
      emit                   = 1'b0;
      emit_item.character    = CHAR_ZERO;
      emit_item.last         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            div_start    = accept;
            div_dividend = mag_in;
            div_divisor  = base_req;
         end
         ST_DIV: begin
            // each remainder is the next digit up; keep dividing until zero
            push      = div_done;
            div_start = div_done && !quot_zero;
         end
         ST_SIGN: begin
            emit                = out_free;
            emit_item.character = CHAR_MINUS;
         end
         ST_PFX0: begin
            emit                = out_free;
            emit_item.character = CHAR_ZERO;
         end
         ST_PFXX: begin
            emit                = out_free;
            emit_item.character = CHAR_X;
         end
         ST_DIG_WAIT: begin
            // stack read data settles during this cycle
         end
         ST_DIG: begin
            emit                = out_free;
            pop                 = out_free;
            emit_item.character = digit_char(top_digit);
            emit_item.last      = (dig_count == CNT_W'(1));
         end
         default: begin
         end
      endcase
   end

   // per-item settings latched at accept
   assign base_in = accept ? base_req : base_ff;
   assign neg_in  = accept ? neg_req  : neg_ff;

   // output register: load on emit, clear once taken
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_item;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= RADIX_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
      end
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   itr_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   itr_digit_stack #(
      .DEPTH(VALUE_BITS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_digit(div_rem),
      .pop       (pop),
      .count     (dig_count),
      .top_digit (top_digit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/itr_checker.sv @@
// ----------------------------------------------------------------------------
// itr_checker
// Port-level checks for integer_to_radix_text, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itr_checker
   import itr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // reset leaves the block empty and ready
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("itr: not idle after reset");

   // an accepted item keeps the block busy for at least the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("itr: input taken again right after accept");

   // only '-', digits, upper-case letters and 'x' ever come out
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.character == CHAR_MINUS)
                 || (rsp_data.character == CHAR_X)
                 || ((rsp_data.character >= CHAR_ZERO) && (rsp_data.character <= 8'h39))
                 || ((rsp_data.character >= CHAR_A) && (rsp_data.character <= 8'h55)))
      else $error("itr: character outside expected set");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("itr: stalled result changed");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (.*);

`default_nettype wire
